FILE: hw/rtl/fbdp_pkg.sv
package fbdp_pkg;

   localparam int ScreenWidth = 128;
   localparam int PageCount   = 8;
   localparam int StoreBytes  = ScreenWidth * PageCount;
   localparam int PageBits    = $clog2(PageCount);
   localparam int AddrBits    = $clog2(StoreBytes);
   localparam int CountBits   = $clog2(StoreBytes + 1);
   localparam int GlyphCols   = 6;
   localparam int MaskBits    = 8;
   localparam logic [MaskBits-1:0] AllDirty = 8'hFF;

   typedef enum logic [2:0] {
      OP_PUT_CHAR    = 3'd0,
      OP_FILL        = 3'd1,
      OP_PICK_DIRTY  = 3'd2,
      OP_READ_BYTE   = 3'd3,
      OP_CLEAR_DIRTY = 3'd4,
      OP_MARK_DIRTY  = 3'd5
   } op_type;

   typedef struct packed {
      logic                set_en;
      logic                clr_en;
      logic [PageBits-1:0] page;
   } dirty_cmd_type;

   // 6x8 font, first column in the top byte; non-printable codes give a space
   function automatic logic [47:0] glyph_row(input logic [7:0] code);
      logic [47:0] row;
      case (code)
         8'h21: row = 48'h00005F000000;
         8'h22: row = 48'h000700070000;
         8'h23: row = 48'h147F147F1400;
         8'h24: row = 48'h242A7F2A1200;
         8'h25: row = 48'h231308646200;
         8'h26: row = 48'h364955225000;
         8'h27: row = 48'h000503000000;
         8'h28: row = 48'h001C22410000;
         8'h29: row = 48'h0041221C0000;
         8'h2A: row = 48'h082A1C2A0800;
         8'h2B: row = 48'h08083E080800;
         8'h2C: row = 48'h005030000000;
         8'h2D: row = 48'h080808080800;
         8'h2E: row = 48'h006060000000;
         8'h2F: row = 48'h201008040200;
         8'h30: row = 48'h3E5149453E00;
         8'h31: row = 48'h00427F400000;
         8'h32: row = 48'h426151494600;
         8'h33: row = 48'h2141454B3100;
         8'h34: row = 48'h1814127F1000;
         8'h35: row = 48'h274545453900;
         8'h36: row = 48'h3C4A49493000;
         8'h37: row = 48'h017109050300;
         8'h38: row = 48'h364949493600;
         8'h39: row = 48'h064949291E00;
         8'h3A: row = 48'h003636000000;
         8'h3B: row = 48'h005636000000;
         8'h3C: row = 48'h000814224100;
         8'h3D: row = 48'h141414141400;
         8'h3E: row = 48'h412214080000;
         8'h3F: row = 48'h020151090600;
         8'h40: row = 48'h324979413E00;
         8'h41: row = 48'h7E1111117E00;
         8'h42: row = 48'h7F4949493600;
         8'h43: row = 48'h3E4141412200;
         8'h44: row = 48'h7F4141221C00;
         8'h45: row = 48'h7F4949494100;
         8'h46: row = 48'h7F0909010100;
         8'h47: row = 48'h3E4141513200;
         8'h48: row = 48'h7F0808087F00;
         8'h49: row = 48'h00417F410000;
         8'h4A: row = 48'h2040413F0100;
         8'h4B: row = 48'h7F0814224100;
         8'h4C: row = 48'h7F4040404000;
         8'h4D: row = 48'h7F0204027F00;
         8'h4E: row = 48'h7F0408107F00;
         8'h4F: row = 48'h3E4141413E00;
         8'h50: row = 48'h7F0909090600;
         8'h51: row = 48'h3E4151215E00;
         8'h52: row = 48'h7F0919294600;
         8'h53: row = 48'h464949493100;
         8'h54: row = 48'h01017F010100;
         8'h55: row = 48'h3F4040403F00;
         8'h56: row = 48'h1F2040201F00;
         8'h57: row = 48'h7F2018207F00;
         8'h58: row = 48'h631408146300;
         8'h59: row = 48'h030478040300;
         8'h5A: row = 48'h615149454300;
         8'h5B: row = 48'h00007F414100;
         8'h5C: row = 48'h020408102000;
         8'h5D: row = 48'h41417F000000;
         8'h5E: row = 48'h040201020400;
         8'h5F: row = 48'h404040404000;
         8'h60: row = 48'h000102040000;
         8'h61: row = 48'h205454547800;
         8'h62: row = 48'h7F4844443800;
         8'h63: row = 48'h384444442000;
         8'h64: row = 48'h384444487F00;
         8'h65: row = 48'h385454541800;
         8'h66: row = 48'h087E09010200;
         8'h67: row = 48'h081454543C00;
         8'h68: row = 48'h7F0804047800;
         8'h69: row = 48'h00447D400000;
         8'h6A: row = 48'h2040443D0000;
         8'h6B: row = 48'h007F10284400;
         8'h6C: row = 48'h00417F400000;
         8'h6D: row = 48'h7C0418047800;
         8'h6E: row = 48'h7C0804047800;
         8'h6F: row = 48'h384444443800;
         8'h70: row = 48'h7C1414140800;
         8'h71: row = 48'h081414187C00;
         8'h72: row = 48'h7C0804040800;
         8'h73: row = 48'h485454542000;
         8'h74: row = 48'h043F44402000;
         8'h75: row = 48'h3C4040207C00;
         8'h76: row = 48'h1C2040201C00;
         8'h77: row = 48'h3C4030403C00;
         8'h78: row = 48'h442810284400;
         8'h79: row = 48'h0C5050503C00;
         8'h7A: row = 48'h4464544C4400;
         8'h7B: row = 48'h000836410000;
         8'h7C: row = 48'h00007F000000;
         8'h7D: row = 48'h004136080000;
         8'h7E: row = 48'h080408100800;
         default: row = 48'h000000000000;
      endcase
      return row;
   endfunction

   function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
      logic [47:0] row;
      logic [7:0]  data;
      row = glyph_row(code);
      case (col)
         3'd0: data = row[47:40];
         3'd1: data = row[39:32];
         3'd2: data = row[31:24];
         3'd3: data = row[23:16];
         3'd4: data = row[15:8];
         3'd5: data = row[7:0];
         default: data = 8'h00;
      endcase
      return data;
   endfunction

endpackage

FILE: hw/rtl/fbdp_frame_ram.sv
module fbdp_frame_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [fbdp_pkg::AddrBits-1:0] wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic                          rd_en,
   input  logic [fbdp_pkg::AddrBits-1:0] rd_addr,
   output logic [7:0]                    rd_data
);

   logic [7:0] mem_ff [fbdp_pkg::StoreBytes];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/fbdp_dirty_tracker.sv
module fbdp_dirty_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  fbdp_pkg::dirty_cmd_type       cmd,
   output logic [fbdp_pkg::MaskBits-1:0] mask,
   output logic                          found,
   output logic [2:0]                    pick
);

   logic [fbdp_pkg::MaskBits-1:0] mask_ff;
   logic [fbdp_pkg::MaskBits-1:0] mask_in;

   always_comb begin
      mask_in = mask_ff;
      if (cmd.set_en) begin
         mask_in[cmd.page] = 1'b1;
      end else if (cmd.clr_en) begin
         mask_in[cmd.page] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= fbdp_pkg::AllDirty;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // lowest dirty page; the mask has one bit per page
   always_comb begin
      found = 1'b0;
      pick  = 3'd0;
      for (int p = fbdp_pkg::PageCount - 1; p >= 0; p--) begin
         if (mask_ff[p]) begin
            found = 1'b1;
            pick  = 3'(p);
         end
      end
   end

   assign mask = mask_ff;

endmodule

FILE: hw/rtl/glyph_framebuffer_dirty_pages.sv
// Page framebuffer (8 pages x 128 column bytes) with a dirty-page mask.
// A command is taken when start is high and busy is low; its fields are
// req_op, req_column, req_page_index and req_value. Each command returns
// exactly one result, shown for a single cycle with rsp_valid high; the
// receiver cannot hold it off, so it must take it in that cycle.
// From acceptance to the result strobe:
//   pick_dirty, read_byte, clear_dirty, mark_dirty, ignored: strobe in the next cycle
//   put_char: one read-compare-write per glyph column left after clipping (at most 6)
//   fill: one read-compare-write per byte through the frame RAM
// The frame RAM has one read and one write port with a registered read; the
// byte sweeps issue one read per cycle and write back in the cycle after, so
// their length sets the rate. busy stays high from acceptance through the
// result cycle, so the next command can be taken in the cycle after the strobe.
// rsp_dirty_mask tracks the mask and is valid at the strobe.
// After reset the block clears all 1024 bytes of the frame RAM, one byte per
// cycle, with busy high; the dirty mask comes up all ones.
module glyph_framebuffer_dirty_pages (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_op,
   input  logic [7:0]                    req_column,
   input  logic [7:0]                    req_page_index,
   input  logic [7:0]                    req_value,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_read_data,
   output logic                          rsp_dirty_found,
   output logic [2:0]                    rsp_dirty_page,
   output logic [fbdp_pkg::MaskBits-1:0] rsp_dirty_mask,
   output logic                          rsp_changed,
   output logic                          rsp_ignored
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_RESP
   } state_type;

   localparam int AW = fbdp_pkg::AddrBits;
   localparam int CW = fbdp_pkg::CountBits;
   localparam int PW = fbdp_pkg::PageBits;

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [7:0]        val_ff, val_in;
   logic              fill_ff, fill_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic [7:0]        expect_ff, expect_in;
   logic              chg_ff, chg_in;
   logic              ign_ff, ign_in;

   logic              pos_bad, page_bad;
   logic [AW-1:0]     req_addr;
   logic [CW-1:0]     room;
   logic              issue;
   logic [AW-1:0]     walk_addr;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;

   fbdp_pkg::dirty_cmd_type      dirty_cmd;
   logic [fbdp_pkg::MaskBits-1:0] mask;
   logic              found;
   logic [2:0]        pick;

   assign page_bad  = req_page_index >= 8'(fbdp_pkg::PageCount);
   assign pos_bad   = page_bad || ({1'b0, req_column} >= 9'(fbdp_pkg::ScreenWidth));
   assign req_addr  = AW'(req_page_index[PW-1:0]) * AW'(fbdp_pkg::ScreenWidth)
                    + AW'(req_column);
   assign room      = CW'(fbdp_pkg::ScreenWidth) - CW'(req_column);
   assign issue     = idx_ff < count_ff;
   assign walk_addr = base_ff + idx_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      base_in      = base_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      fill_in      = fill_ff;
      pend_in      = 1'b0;
      pend_addr_in = walk_addr;
      expect_in    = fill_ff ? val_ff : fbdp_pkg::glyph_col(val_ff, idx_ff[2:0]);
      chg_in       = chg_ff;
      ign_in       = ign_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = expect_ff;
      rd_en        = 1'b0;
      rd_addr      = walk_addr;
      dirty_cmd    = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = 8'h00;
            idx_in  = idx_ff + CW'(1);
            if (idx_ff == CW'(fbdp_pkg::StoreBytes - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in    = req_op;
               val_in   = req_value;
               idx_in   = '0;
               chg_in   = 1'b0;
               ign_in   = 1'b0;
               state_in = ST_RESP;
               rd_addr  = req_addr;
               case (req_op)
                  fbdp_pkg::OP_PUT_CHAR: begin
                     if (pos_bad) begin
                        ign_in = 1'b1;
                     end else begin
                        base_in  = req_addr;
                        count_in = (room > CW'(fbdp_pkg::GlyphCols)) ?
                                   CW'(fbdp_pkg::GlyphCols) : room;
                        fill_in  = 1'b0;
                        state_in = ST_WALK;
                     end
                  end
                  fbdp_pkg::OP_FILL: begin
                     base_in  = '0;
                     count_in = CW'(fbdp_pkg::StoreBytes);
                     fill_in  = 1'b1;
                     state_in = ST_WALK;
                  end
                  fbdp_pkg::OP_PICK_DIRTY: begin
                  end
                  fbdp_pkg::OP_READ_BYTE: begin
                     if (pos_bad) begin
                        ign_in = 1'b1;
                     end else begin
                        rd_en = 1'b1;
                     end
                  end
                  fbdp_pkg::OP_CLEAR_DIRTY: begin
                     if (page_bad) begin
                        ign_in = 1'b1;
                     end else begin
                        dirty_cmd.clr_en = 1'b1;
                        dirty_cmd.page   = req_page_index[PW-1:0];
                     end
                  end
                  fbdp_pkg::OP_MARK_DIRTY: begin
                     if (page_bad) begin
                        ign_in = 1'b1;
                     end else begin
                        dirty_cmd.set_en = 1'b1;
                        dirty_cmd.page   = req_page_index[PW-1:0];
                     end
                  end
                  default: begin
                     ign_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // read one byte ahead, write back the previous one if it differs
            if (issue) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               idx_in  = idx_ff + CW'(1);
            end
            if (pend_ff && (rd_data != expect_ff)) begin
               wr_en            = 1'b1;
               chg_in           = 1'b1;
               dirty_cmd.set_en = 1'b1;
               dirty_cmd.page   = PW'(pend_addr_ff / fbdp_pkg::ScreenWidth);
            end
            if (!issue && !pend_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
      end
      op_ff        <= op_in;
      base_ff      <= base_in;
      count_ff     <= count_in;
      val_ff       <= val_in;
      fill_ff      <= fill_in;
      pend_addr_ff <= pend_addr_in;
      expect_ff    <= expect_in;
      chg_ff       <= chg_in;
      ign_ff       <= ign_in;
   end

   fbdp_frame_ram u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fbdp_dirty_tracker u_dirty_tracker (
      .clock (clock),
      .reset (reset),
      .cmd   (dirty_cmd),
      .mask  (mask),
      .found (found),
      .pick  (pick)
   );

   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = state_ff == ST_RESP;
   assign rsp_read_data   = (op_ff == fbdp_pkg::OP_READ_BYTE && !ign_ff) ? rd_data : 8'h00;
   assign rsp_dirty_found = (op_ff == fbdp_pkg::OP_PICK_DIRTY) ? found : 1'b0;
   assign rsp_dirty_page  = (op_ff == fbdp_pkg::OP_PICK_DIRTY) ? pick : 3'd0;
   assign rsp_dirty_mask  = mask;
   assign rsp_changed     = chg_ff;
   assign rsp_ignored     = ign_ff;

endmodule
